// ===== src/assert_macros.svh =====
// Assertion macros shared by the queue bank RTL.
// Depends on nothing; included by modules that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);
// Implication checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);
`endif

// ===== src/bdpq_pkg.sv =====
// Package for the double-ended priority queue bank: event codes, opcodes and the result word.
// Depends on nothing.
`timescale 1ns / 1ps
package bdpq_pkg;
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_QUOTA = 2'd1;
  localparam logic [1:0] OP_DROP  = 2'd2;
  localparam logic [1:0] OP_PRINT = 2'd3;

  localparam logic [2:0] EV_ADDED    = 3'd0;
  localparam logic [2:0] EV_DROPPED  = 3'd1;
  localparam logic [2:0] EV_PRINTED  = 3'd2;
  localparam logic [2:0] EV_NOJOBS   = 3'd3;
  localparam logic [2:0] EV_QUOTA    = 3'd4;
  localparam logic [2:0] EV_OVERFLOW = 3'd5;

  // One result word as it leaves the sequencer.
  typedef struct packed {
    logic [2:0]  ev;
    logic [63:0] key;
    logic        has_key;
    logic [2:0]  q;
    logic [15:0] lim;
    logic        last;
  } res_t;
endpackage

// ===== src/bounded_double_ended_priority_queues.sv =====
// Top level of the double-ended priority queue bank.
// Depends on bdpq_pkg and assert_macros.svh.
//
// Usage: one input word per operation on in_valid_i/in_ready_o; each word
// yields one to QUEUE_DEPTH+1 result words on out_valid_o/out_ready_i, the
// final one flagged by last_o. Jobs are ordered by signed priority, then
// signed job number. Each queue is an unordered slot array in one memory;
// removals scan the live slots with one shared key comparator, one slot per
// cycle through the registered memory read port.
// An add is dispatched and emitted, after a removal when its queue is at
// quota; a drop or print scans all live jobs, moves the last slot into
// the hole and emits; a quota trim does that per job removed. One word is
// in work at a time; in_ready_o is low until its last result is taken.
// Reset clears all sizes and quotas at once; no clearing pass is needed
// since only slots below the size are read. When the receiver stalls the
// result register holds and the sequencer waits.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bounded_double_ended_priority_queues #(
  parameter int NUM_QUEUES  = 8,
  parameter int QUEUE_DEPTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic [2:0]         queue_id_i,
  input  logic signed [31:0] job_number_i,
  input  logic signed [31:0] job_priority_i,
  input  logic [15:0]        limit_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         event_res_o,
  output logic signed [31:0] out_job_o,
  output logic signed [31:0] out_priority_o,
  output logic [2:0]         out_queue_o,
  output logic [15:0]        out_limit_o,
  output logic               last_o
);
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int SW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int AW = QW + IW;
  localparam int MD = 2 ** AW;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_RD0, S_SCAN, S_MOVE, S_WMOVE, S_AFTER, S_EMIT, S_WAIT
  } state_e;

  state_e state_q;
  logic [1:0]  op_q;
  logic [2:0]  qid_q;
  logic [QW-1:0] qi_q;
  logic [63:0] key_in_q;
  logic [15:0] lim_q;
  logic [SW-1:0] size_q [NUM_QUEUES];
  logic [15:0] quota_q [NUM_QUEUES];
  logic        qv_q [NUM_QUEUES];
  logic [63:0] mem [MD];
  logic [63:0] rd_q;
  logic [AW-1:0] raddr;
  logic          ren;
  logic [SW-1:0] scan_q;
  logic [IW-1:0] best_q, ridx;
  logic [63:0]   best_key_q;
  logic          want_max_q;
  logic          cont_q;   // after a removal, go on with the add
  logic          quota_loop_q;
  bdpq_pkg::res_t res_q;
  logic          res_v_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [63:0]   mem_wdata;

  logic [SW-1:0] cur_sz;
  assign cur_sz = size_q[qi_q];

  // Write port: the last slot moves into the hole, or a new job is appended.
  always_comb begin
    mem_we = 1'b0;
    mem_waddr = {qi_q, best_q};
    mem_wdata = rd_q;
    if (state_q == S_WMOVE && !res_v_q) begin
      mem_we = 1'b1;
    end else if (state_q == S_EMIT && !res_v_q && !quota_loop_q &&
                 32'(cur_sz) < QUEUE_DEPTH) begin
      mem_we = 1'b1;
      mem_waddr = {qi_q, IW'(cur_sz)};
      mem_wdata = key_in_q;
    end
  end

  // Memory with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (ren) rd_q <= mem[raddr];
  end

  assign raddr = {qi_q, ridx};
  assign ren = (state_q == S_RD0) || (state_q == S_SCAN) || (state_q == S_MOVE);
  always_comb begin
    ridx = IW'(scan_q);
    if (state_q == S_MOVE) ridx = IW'(cur_sz - SW'(1));
  end

  // Shared key comparator.
  logic better;
  assign better = want_max_q ? (rd_q > best_key_q) : (rd_q < best_key_q);

  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = res_v_q;
  assign event_res_o = res_q.ev;
  assign out_job_o = res_q.has_key ? (res_q.key[31:0] ^ 32'h8000_0000) : '0;
  assign out_priority_o = res_q.has_key ? (res_q.key[63:32] ^ 32'h8000_0000) : '0;
  assign out_queue_o = res_q.q;
  assign out_limit_o = res_q.lim;
  assign last_o = res_q.last;

  // Sequencer: dispatch, slot scan, move-last-into-hole, result emission.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_v_q <= 1'b0;
      qi_q <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        size_q[i] <= '0;
        quota_q[i] <= '0;
        qv_q[i] <= 1'b0;
      end
      cont_q <= 1'b0;
      quota_loop_q <= 1'b0;
    end else begin
      if (res_v_q && out_ready_i) res_v_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q <= opcode_i;
            qid_q <= queue_id_i;
            qi_q <= QW'(queue_id_i);
            key_in_q <= {job_priority_i ^ 32'h8000_0000, job_number_i ^ 32'h8000_0000};
            lim_q <= limit_i;
            state_q <= S_DISP;
          end
        end
        S_DISP: begin
          if (!res_v_q) begin
            cont_q <= 1'b0;
            quota_loop_q <= 1'b0;
            if (32'(qid_q) >= NUM_QUEUES) begin
              res_q <= '{ev: bdpq_pkg::EV_NOJOBS, key: '0, has_key: 1'b0, q: qid_q,
                         lim: '0, last: 1'b1};
              res_v_q <= 1'b1;
              state_q <= S_WAIT;
            end else begin
              case (op_q)
                bdpq_pkg::OP_ADD: begin
                  if (qv_q[qi_q] && 16'(cur_sz) >= quota_q[qi_q]) begin
                    cont_q <= 1'b1;
                    want_max_q <= 1'b0;
                    state_q <= S_RD0;
                    scan_q <= '0;
                  end else begin
                    state_q <= S_AFTER;
                  end
                end
                bdpq_pkg::OP_QUOTA: begin
                  quota_q[qi_q] <= lim_q;
                  qv_q[qi_q] <= 1'b1;
                  quota_loop_q <= 1'b1;
                  want_max_q <= 1'b0;
                  state_q <= S_AFTER;
                end
                default: begin
                  want_max_q <= (op_q == bdpq_pkg::OP_PRINT);
                  scan_q <= '0;
                  state_q <= S_RD0;
                end
              endcase
            end
          end
        end
        S_RD0: begin
          if (cur_sz == '0) begin
            if (!res_v_q) begin
              res_q <= '{ev: bdpq_pkg::EV_NOJOBS, key: '0, has_key: 1'b0, q: qid_q,
                         lim: '0, last: !cont_q};
              res_v_q <= 1'b1;
              state_q <= cont_q ? S_AFTER : S_WAIT;
            end
          end else begin
            scan_q <= SW'(1);
            best_q <= '0;
            best_key_q <= want_max_q ? '0 : '1;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          // rd_q holds slot scan_q-1
          if (better || scan_q == SW'(1)) begin
            best_key_q <= rd_q;
            best_q <= IW'(scan_q - SW'(1));
          end
          if (scan_q >= cur_sz) state_q <= S_MOVE;
          else scan_q <= scan_q + SW'(1);
        end
        S_MOVE: begin
          state_q <= S_WMOVE;
        end
        S_WMOVE: begin
          if (!res_v_q) begin
            size_q[qi_q] <= cur_sz - SW'(1);
            res_q <= '{ev: want_max_q ? bdpq_pkg::EV_PRINTED : bdpq_pkg::EV_DROPPED,
                       key: best_key_q, has_key: 1'b1, q: qid_q, lim: '0,
                       last: !(cont_q || quota_loop_q)};
            res_v_q <= 1'b1;
            state_q <= (cont_q || quota_loop_q) ? S_AFTER : S_WAIT;
          end
        end
        S_AFTER: begin
          if (quota_loop_q) begin
            if (16'(cur_sz) > lim_q) begin
              scan_q <= '0;
              state_q <= S_RD0;
            end else begin
              state_q <= S_EMIT;
            end
          end else begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!res_v_q) begin
            if (quota_loop_q) begin
              res_q <= '{ev: bdpq_pkg::EV_QUOTA, key: '0, has_key: 1'b0, q: qid_q,
                         lim: lim_q, last: 1'b1};
            end else if (32'(cur_sz) >= QUEUE_DEPTH) begin
              res_q <= '{ev: bdpq_pkg::EV_OVERFLOW, key: key_in_q, has_key: 1'b1,
                         q: qid_q, lim: '0, last: 1'b1};
            end else begin
              size_q[qi_q] <= cur_sz + SW'(1);
              res_q <= '{ev: bdpq_pkg::EV_ADDED, key: key_in_q, has_key: 1'b1,
                         q: qid_q, lim: '0, last: 1'b1};
            end
            res_v_q <= 1'b1;
            state_q <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (!res_v_q || out_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni, state_q != S_IDLE, !in_ready_o,
    "input accepted while busy")
  `ASSERT_IMPL(a_size_bound, clk_i, rst_ni, 1'b1, 32'(cur_sz) <= QUEUE_DEPTH,
    "queue size beyond depth")
  `ASSERT_NEXT(a_idle_no_out, clk_i, rst_ni, state_q == S_IDLE && !out_valid_o,
    !out_valid_o, "result without work")
endmodule

// ===== dv/bounded_double_ended_priority_queues_test.sv =====
// Testbench for the double-ended priority queue bank: directed and random operations,
// checked word by word against a behavioral model of the queues. Depends on bdpq_pkg.
`timescale 1ns / 1ps

class queue_bank_scoreboard;
  // One expected result word.
  typedef struct {
    logic [2:0]  ev;
    logic [31:0] job;
    logic [31:0] prio;
    logic [2:0]  q;
    logic [15:0] lim;
    logic        last;
  } result_word_t;

  logic [63:0]  jobs[8][$];
  int unsigned  quota_lim[8];
  bit           quota_on[8];
  result_word_t pending_results[$];
  int           failures;
  int           words_checked;

  function new();
    failures = 0;
    words_checked = 0;
    for (int i = 0; i < 8; i++) begin
      jobs[i].delete();
      quota_lim[i] = 0;
      quota_on[i] = 0;
    end
  endfunction

  // Sort key: offset binary priority over offset binary job number.
  function logic [63:0] job_key(logic [31:0] job, logic [31:0] prio);
    return {prio ^ 32'h8000_0000, job ^ 32'h8000_0000};
  endfunction

  function void push_word(logic [2:0] ev, logic [63:0] key, bit has_key, logic [2:0] q,
                          logic [15:0] lim);
    result_word_t w;
    w.ev = ev;
    w.job = has_key ? key[31:0] ^ 32'h8000_0000 : 32'd0;
    w.prio = has_key ? key[63:32] ^ 32'h8000_0000 : 32'd0;
    w.q = q;
    w.lim = lim;
    w.last = 0;
    pending_results.insert(pending_results.size(), w);
  endfunction

  // Remove the minimum or maximum job of a queue.
  function void remove_extreme(logic [2:0] q, bit want_max);
    int best;
    logic [63:0] key;
    best = 0;
    if (jobs[q].size() == 0) begin
      push_word(bdpq_pkg::EV_NOJOBS, 64'd0, 0, q, 16'd0);
      return;
    end
    for (int i = 1; i < jobs[q].size(); i++)
      if (want_max ? jobs[q][i] > jobs[q][best] : jobs[q][i] < jobs[q][best]) best = i;
    key = jobs[q][best];
    jobs[q].delete(best);
    push_word(want_max ? bdpq_pkg::EV_PRINTED : bdpq_pkg::EV_DROPPED, key, 1, q, 16'd0);
  endfunction

  // Note an accepted input word and queue its expected results.
  function void note_operation(logic [1:0] op, logic [2:0] q, logic [31:0] job,
                               logic [31:0] prio, logic [15:0] lim);
    logic [63:0] key;
    key = job_key(job, prio);
    case (op)
      bdpq_pkg::OP_ADD: begin
        if (quota_on[q] && jobs[q].size() >= quota_lim[q]) remove_extreme(q, 0);
        if (jobs[q].size() >= 32) begin
          push_word(bdpq_pkg::EV_OVERFLOW, key, 1, q, 16'd0);
        end else begin
          jobs[q].insert(jobs[q].size(), key);
          push_word(bdpq_pkg::EV_ADDED, key, 1, q, 16'd0);
        end
      end
      bdpq_pkg::OP_QUOTA: begin
        quota_lim[q] = lim;
        quota_on[q] = 1;
        while (jobs[q].size() > lim) remove_extreme(q, 0);
        push_word(bdpq_pkg::EV_QUOTA, 64'd0, 0, q, lim);
      end
      bdpq_pkg::OP_DROP: remove_extreme(q, 0);
      default: remove_extreme(q, 1);
    endcase
    pending_results[$].last = 1;
  endfunction

  // Compare one accepted result word with the oldest expectation.
  function void check_word(logic [2:0] ev, logic [31:0] job, logic [31:0] prio,
                           logic [2:0] q, logic [15:0] lim, logic last);
    result_word_t w;
    if (pending_results.size() == 0) begin
      $error("unexpected result word: event %0d queue %0d", ev, q);
      failures++;
      return;
    end
    w = pending_results.pop_front();
    words_checked++;
    if (ev !== w.ev) begin
      $error("event_res: expected %0d, got %0d", w.ev, ev); failures++;
    end
    if (job !== w.job) begin
      $error("out_job: expected %0h, got %0h", w.job, job); failures++;
    end
    if (prio !== w.prio) begin
      $error("out_priority: expected %0h, got %0h", w.prio, prio); failures++;
    end
    if (q !== w.q) begin
      $error("out_queue: expected %0d, got %0d", w.q, q); failures++;
    end
    if (lim !== w.lim) begin
      $error("out_limit: expected %0d, got %0d", w.lim, lim); failures++;
    end
    if (last !== w.last) begin
      $error("last: expected %0d, got %0d", w.last, last); failures++;
    end
  endfunction
endclass

module bounded_double_ended_priority_queues_test;
  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         opcode_i;
  logic [2:0]         queue_id_i;
  logic signed [31:0] job_number_i;
  logic signed [31:0] job_priority_i;
  logic [15:0]        limit_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [2:0]         event_res_o;
  logic signed [31:0] out_job_o;
  logic signed [31:0] out_priority_o;
  logic [2:0]         out_queue_o;
  logic [15:0]        out_limit_o;
  logic               last_o;

  queue_bank_scoreboard bank_model;
  int send_idle_pct;
  int recv_stall_pct;
  int ops_sent;

  bounded_double_ended_priority_queues u_dut (.*);

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  // Receiver: random stalls, every accepted word goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      bank_model.check_word(event_res_o, out_job_o, out_priority_o, out_queue_o,
                            out_limit_o, last_o);
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Send one word, with random idle cycles ahead of it, and wait for acceptance.
  task automatic send_op(logic [1:0] op, logic [2:0] q, logic [31:0] job, logic [31:0] prio,
                         logic [15:0] lim);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1;
    opcode_i <= op;
    queue_id_i <= q;
    job_number_i <= job;
    job_priority_i <= prio;
    limit_i <= lim;
    do @(posedge clk_i); while (!in_ready_o);
    bank_model.note_operation(op, q, job, prio, lim);
    ops_sent++;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(7);
      3: return -$urandom_range(7);
      default: return $urandom;
    endcase
  endfunction

  // Random phase: mostly adds on a few queues so that they fill and overflow.
  task automatic random_phase(int count);
    logic [1:0] op;
    logic [15:0] lim;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      op = pick < 60 ? bdpq_pkg::OP_ADD : pick < 70 ? bdpq_pkg::OP_QUOTA :
           pick < 85 ? bdpq_pkg::OP_DROP : bdpq_pkg::OP_PRINT;
      pick = $urandom_range(9);
      lim = pick == 0 ? 16'hffff : pick == 1 ? 16'd0 :
            pick < 4 ? 16'($urandom) : 16'($urandom_range(40));
      send_op(op, $urandom_range(3) == 0 ? 3'($urandom_range(7)) : 3'($urandom_range(1)),
              rand_value(), rand_value(), lim);
    end
  endtask

  initial begin
    bank_model = new();
    ops_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_ni = 0;
    in_valid_i = 0;
    opcode_i = bdpq_pkg::OP_ADD;
    queue_id_i = 3'd0;
    job_number_i = 32'd0;
    job_priority_i = 32'd0;
    limit_i = 16'd0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: empty queues, extremes, ties on priority, quota zero, overflow, trims.
    send_op(bdpq_pkg::OP_DROP, 3'd7, 32'd0, 32'd0, 16'd0);
    send_op(bdpq_pkg::OP_PRINT, 3'd0, 32'd0, 32'd0, 16'd0);
    send_op(bdpq_pkg::OP_ADD, 3'd0, 32'h8000_0000, 32'h8000_0000, 16'd0);
    send_op(bdpq_pkg::OP_ADD, 3'd0, 32'h7fff_ffff, 32'h7fff_ffff, 16'd0);
    send_op(bdpq_pkg::OP_ADD, 3'd0, 32'd5, 32'd1, 16'd0);
    send_op(bdpq_pkg::OP_ADD, 3'd0, -32'sd5, 32'd1, 16'd0);
    send_op(bdpq_pkg::OP_PRINT, 3'd0, 32'd0, 32'd0, 16'd0);
    send_op(bdpq_pkg::OP_DROP, 3'd0, 32'd0, 32'd0, 16'd0);
    send_op(bdpq_pkg::OP_QUOTA, 3'd0, 32'd0, 32'd0, 16'd1);
    send_op(bdpq_pkg::OP_ADD, 3'd0, 32'd9, 32'd9, 16'd0);
    send_op(bdpq_pkg::OP_QUOTA, 3'd1, 32'd0, 32'd0, 16'd0);
    send_op(bdpq_pkg::OP_ADD, 3'd1, 32'd1, -32'sd1, 16'd0);
    send_op(bdpq_pkg::OP_QUOTA, 3'd0, 32'd0, 32'd0, 16'hffff);
    for (int i = 0; i < 33; i++)
      send_op(bdpq_pkg::OP_ADD, 3'd2, $urandom, $urandom, 16'd0);
    send_op(bdpq_pkg::OP_QUOTA, 3'd2, 32'd0, 32'd0, 16'd0);
    send_op(bdpq_pkg::OP_QUOTA, 3'd2, 32'd0, 32'd0, 16'hffff);

    // Random phases with different idling patterns.
    random_phase(18);
    send_idle_pct = 79;
    random_phase(18);
    send_idle_pct = 0;
    recv_stall_pct = 79;
    random_phase(18);
    send_idle_pct = 29;
    recv_stall_pct = 29;
    random_phase(18);
    in_valid_i <= 0;
    recv_stall_pct = 0;

    while (bank_model.pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Sent %0d operations over eight queues and checked %0d result words.",
             ops_sent, bank_model.words_checked);
    if (bank_model.failures == 0 && bank_model.pending_results.size() == 0) begin
      $display("bounded_double_ended_priority_queues test passed");
    end else begin
      $display("bounded_double_ended_priority_queues test failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("bounded_double_ended_priority_queues test failed");
    $finish;
  end
endmodule
